>>> rtl/raps_pkg.sv
// ----------------------------------------------------------------------------
// raps_pkg
// Shared types and constants for the pairwise rare-allele sharing counter.
// ----------------------------------------------------------------------------
package raps_pkg;

  localparam int unsigned THR_W  = 18;
  localparam int unsigned SCNT_W = 9;
  localparam int unsigned BINR_W = 3;
  localparam int unsigned LIK_W  = 16;
  localparam int unsigned RD_W   = 32;
  localparam int unsigned BIN_REGS = 4;
  localparam logic [2:0] NO_BIN = 3'd4;

  typedef enum logic [1:0] {
    ACT_SAMPLE   = 2'd0,
    ACT_RD_PAIR  = 2'd1,
    ACT_RD_BIN   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_THR   = 3'd0,
    REG_NSAMP = 3'd1,
    REG_NBINS = 3'd2,
    REG_BIN_A = 3'd3,
    REG_BIN_B = 3'd4,
    REG_BIN_C = 3'd5,
    REG_BIN_D = 3'd6,
    REG_NONE  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] lik_hom_ref;
    logic [15:0] lik_het;
    logic [15:0] lik_hom_alt;
    logic [1:0]  bin_select;
    logic [7:0]  row_sample;
    logic [7:0]  col_sample;
  } in_beat_t;

  typedef struct packed {
    logic        result_kind;
    logic [8:0]  site_carriers;
    logic [2:0]  matched_bin;
    logic [31:0] read_value;
  } out_beat_t;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [SCNT_W-1:0] nsamp;
    logic [BINR_W-1:0] nbins;
    logic [SCNT_W-1:0] bin_a;
    logic [SCNT_W-1:0] bin_b;
    logic [SCNT_W-1:0] bin_c;
    logic [SCNT_W-1:0] bin_d;
  } cfg_regs_t;

endpackage

>>> rtl/raps_cfg.sv
// ----------------------------------------------------------------------------
// raps_cfg
// APB register file for threshold, sample count, bin count and bin values.
// ----------------------------------------------------------------------------
module raps_cfg import raps_pkg::*; #(
  parameter int unsigned AW = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AW-1:0]    paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output cfg_regs_t        regs
);

  cfg_regs_t regs_r;
  reg_idx_t  idx;

  assign idx  = reg_idx_t'(paddr[AW-1:2]);
  assign regs = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.thr   <= THR_W'(32768);
      regs_r.nsamp <= SCNT_W'(256);
      regs_r.nbins <= BINR_W'(4);
      regs_r.bin_a <= SCNT_W'(2);
      regs_r.bin_b <= SCNT_W'(3);
      regs_r.bin_c <= SCNT_W'(4);
      regs_r.bin_d <= SCNT_W'(5);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_THR:   regs_r.thr   <= pwdata[THR_W-1:0];
        REG_NSAMP: regs_r.nsamp <= pwdata[SCNT_W-1:0];
        REG_NBINS: regs_r.nbins <= pwdata[BINR_W-1:0];
        REG_BIN_A: regs_r.bin_a <= pwdata[SCNT_W-1:0];
        REG_BIN_B: regs_r.bin_b <= pwdata[SCNT_W-1:0];
        REG_BIN_C: regs_r.bin_c <= pwdata[SCNT_W-1:0];
        REG_BIN_D: regs_r.bin_d <= pwdata[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THR:   prdata = 32'(regs_r.thr);
      REG_NSAMP: prdata = 32'(regs_r.nsamp);
      REG_NBINS: prdata = 32'(regs_r.nbins);
      REG_BIN_A: prdata = 32'(regs_r.bin_a);
      REG_BIN_B: prdata = 32'(regs_r.bin_b);
      REG_BIN_C: prdata = 32'(regs_r.bin_c);
      REG_BIN_D: prdata = 32'(regs_r.bin_d);
      default:   prdata = '0;
    endcase
  end

endmodule

>>> rtl/raps_carrier.sv
// ----------------------------------------------------------------------------
// raps_carrier
// Carrier test without division: (het + 2*alt) * 65536 >= thr * sum.
// ----------------------------------------------------------------------------
module raps_carrier import raps_pkg::*; (
  input  logic [LIK_W-1:0] lik_ref,
  input  logic [LIK_W-1:0] lik_het,
  input  logic [LIK_W-1:0] lik_alt,
  input  logic [THR_W-1:0] thr,
  output logic             carrier
);

  logic [17:0] sum;
  logic [17:0] num;
  logic [35:0] lhs;
  logic [35:0] rhs;

  assign sum = 18'(lik_ref) + 18'(lik_het) + 18'(lik_alt);
  assign num = 18'(lik_het) + {1'b0, lik_alt, 1'b0};
  assign lhs = {2'b00, num, 16'h0000};
  assign rhs = 36'(thr) * 36'(sum);

  always_comb begin
    if (sum == '0) carrier = (thr == '0);
    else           carrier = (lhs >= rhs);
  end

endmodule

>>> rtl/raps_core.sv
// ----------------------------------------------------------------------------
// raps_core
// Site sequencer, carrier list memory, pair-count memory and clearing pass.
// ----------------------------------------------------------------------------
module raps_core import raps_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 256,
  parameter int unsigned NUM_BINS    = 4,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t regs,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int unsigned SW  = $clog2(MAX_SAMPLES);
  localparam int unsigned TW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned AW  = BW + 2 * SW;
  localparam int unsigned DEPTH = NUM_BINS * MAX_SAMPLES * MAX_SAMPLES;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LI    = 7'b0000100,
    S_LJ    = 7'b0001000,
    S_RMW   = 7'b0010000,
    S_RD    = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  st_t st_r;
  logic [AW-1:0] clr_r;
  logic [SW-1:0] pos_r;
  logic [TW-1:0] tally_r;
  logic [TW-1:0] i_r, j_r;
  logic [SW-1:0] ri_r;
  logic [2:0]    match_r;
  logic [1:0]    phase_r;   // 0: (ri,rj), 1: (rj,ri); diagonal uses 0 only
  logic [SW-1:0] rj_r;
  logic          rd_zero_r;
  logic [COUNT_WIDTH-1:0] bsc_r [NUM_BINS];
  out_beat_t     out_r;
  logic          out_v_r;

  // carrier list memory
  logic [SW-1:0] cl_mem [MAX_SAMPLES];
  logic [SW-1:0] cl_q;
  logic          cl_we;
  logic [SW-1:0] cl_wa, cl_ra;

  // pair-count memory
  logic [COUNT_WIDTH-1:0] pc_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] pc_q;
  logic          pc_we;
  logic [AW-1:0] pc_wa, pc_ra;
  logic [COUNT_WIDTH-1:0] pc_wd;

  function automatic logic [RD_W-1:0] sat_rd(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'h0000_0000_FFFF_FFFF) return '1;
    return w[RD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cl_we) cl_mem[cl_wa] <= pos_r;
    cl_q <= cl_mem[cl_ra];
  end

  always_ff @(posedge clk) begin
    if (pc_we) pc_mem[pc_wa] <= pc_wd;
    pc_q <= pc_mem[pc_ra];
  end

  logic carrier;
  raps_carrier u_car (
    .lik_ref(in_data.lik_hom_ref), .lik_het(in_data.lik_het),
    .lik_alt(in_data.lik_hom_alt), .thr(regs.thr), .carrier(carrier)
  );

  // effective sample count and bin count
  logic [TW-1:0] n_eff;
  logic [2:0]    nb_eff;
  always_comb begin
    if (regs.nsamp == '0) n_eff = TW'(1);
    else if (32'(regs.nsamp) > MAX_SAMPLES) n_eff = TW'(MAX_SAMPLES);
    else n_eff = TW'(regs.nsamp);
    nb_eff = regs.nbins;
    if (32'(nb_eff) > NUM_BINS) nb_eff = 3'(NUM_BINS);
    if (nb_eff > 3'(BIN_REGS)) nb_eff = 3'(BIN_REGS);
  end

  logic [SCNT_W-1:0] bval [BIN_REGS];
  assign bval[0] = regs.bin_a;
  assign bval[1] = regs.bin_b;
  assign bval[2] = regs.bin_c;
  assign bval[3] = regs.bin_d;

  logic        take;
  logic        is_car;
  logic [TW-1:0] tally_inc;
  logic        last;
  logic [2:0]  match;
  assign take   = in_valid && in_ready;
  assign is_car = carrier && (32'(tally_r) < MAX_SAMPLES);
  assign tally_inc = tally_r + TW'(is_car);
  assign last   = (32'(pos_r) + 1 >= 32'(n_eff));

  always_comb begin
    match = NO_BIN;
    for (int b = BIN_REGS - 1; b >= 0; b--) begin
      if (3'(b) < nb_eff && 32'(bval[b]) == 32'(tally_inc)) match = 3'(b);
    end
  end

  assign in_ready = (st_r == S_IDLE) && !out_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  logic [BW-1:0] mb;
  assign mb = BW'(match_r);

  // read address logic
  logic rd_ok;
  always_comb begin
    rd_ok = (3'(in_data.bin_select) < nb_eff) &&
            (32'(in_data.row_sample) < 32'(n_eff)) &&
            (32'(in_data.col_sample) < 32'(n_eff));
  end

  always_comb begin
    cl_we = take && in_data.action == ACT_SAMPLE && is_car;
    cl_wa = tally_r[SW-1:0];
    cl_ra = '0;
    pc_we = 1'b0;
    pc_wa = '0;
    pc_wd = '0;
    pc_ra = '0;
    unique case (st_r)
      S_CLEAR: begin
        pc_we = 1'b1;
        pc_wa = clr_r;
      end
      S_IDLE: begin
        cl_ra = '0;
        pc_ra = {BW'(in_data.bin_select), SW'(in_data.row_sample),
                 SW'(in_data.col_sample)};
      end
      S_LI: cl_ra = i_r[SW-1:0];
      S_LJ: begin
        cl_ra = j_r[SW-1:0];
        pc_ra = {mb, (j_r == i_r) ? cl_q : ri_r, cl_q};
      end
      S_RMW: begin
        pc_we = 1'b1;
        pc_wa = (phase_r == 2'd1) ? {mb, rj_r, ri_r} : {mb, ri_r, rj_r};
        pc_wd = (pc_q == CMAX) ? pc_q : pc_q + 1'b1;
        pc_ra = {mb, rj_r, ri_r};
      end
      S_RD: ;
      S_OUT: cl_ra = j_r[SW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      clr_r   <= '0;
      pos_r   <= '0;
      tally_r <= '0;
      out_v_r <= 1'b0;
      for (int b = 0; b < NUM_BINS; b++) bsc_r[b] <= '0;
    end else begin
      if (out_v_r && out_ready) out_v_r <= 1'b0;
      unique case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (take) begin
            case (in_data.action)
              ACT_SAMPLE: begin
                if (!last) begin
                  tally_r <= tally_inc;
                  pos_r   <= pos_r + 1'b1;
                end else begin
                  pos_r   <= '0;
                  match_r <= match;
                  out_r   <= '{result_kind: 1'b0, site_carriers: 9'(tally_inc),
                               matched_bin: match, read_value: '0};
                  if (match != NO_BIN && bsc_r[BW'(match)] != CMAX)
                    bsc_r[BW'(match)] <= bsc_r[BW'(match)] + 1'b1;
                  if (match != NO_BIN && tally_inc != '0) begin
                    tally_r <= tally_inc;
                    i_r     <= '0;
                    st_r    <= S_LI;
                  end else begin
                    tally_r <= '0;
                    out_v_r <= 1'b1;
                  end
                end
              end
              ACT_RD_BIN: begin
                out_r <= '{result_kind: 1'b1, site_carriers: '0, matched_bin: '0,
                           read_value: (3'(in_data.bin_select) < nb_eff) ?
                             sat_rd(bsc_r[BW'(in_data.bin_select)]) : '0};
                out_v_r <= 1'b1;
              end
              ACT_RD_PAIR: begin
                rd_zero_r <= !rd_ok;
                st_r <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_LI: begin
          j_r  <= i_r;
          st_r <= S_LJ;
        end
        S_LJ: begin
          if (j_r == i_r) ri_r <= cl_q;
          rj_r    <= cl_q;
          phase_r <= 2'd0;
          st_r    <= S_RMW;
        end
        S_RMW: begin
          if (phase_r == 2'd0 && rj_r != ri_r) begin
            phase_r <= 2'd1;
          end else if (j_r + 1'b1 < tally_r) begin
            j_r  <= j_r + 1'b1;
            st_r <= S_OUT;
          end else if (i_r + 1'b1 < tally_r) begin
            i_r  <= i_r + 1'b1;
            st_r <= S_LI;
          end else begin
            tally_r <= '0;
            out_v_r <= 1'b1;
            st_r    <= S_IDLE;
          end
        end
        S_OUT: st_r <= S_LJ;   // next column: reload list entry and cell
        S_RD: begin
          out_r <= '{result_kind: 1'b1, site_carriers: '0, matched_bin: '0,
                     read_value: rd_zero_r ? '0 : sat_rd(pc_q)};
          out_v_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/rare_allele_pair_sharing.sv
// ----------------------------------------------------------------------------
// rare_allele_pair_sharing
// Pairwise rare-allele sharing counter with APB configuration.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | beat
// in_     | in  | in_valid/ready   | in_beat_t
// out_    | out | out_valid/ready  | out_beat_t
// cfg_    | in  | APB, pready = 1  | 32-bit register
// Sample beats are taken only while idle. A finished site with a matching bin
// and at least one carrier walks its carrier pairs through the pair-count
// memory: one read-modify-write per diagonal cell, two per off-diagonal pair.
// Bin reads answer from the bin-count registers, pair reads via state S_RD; a
// waiting result beat holds in_ready low. After reset a clearing pass over
// all NUM_BINS*MAX_SAMPLES^2 pair-count cells runs before the first beat.
// ----------------------------------------------------------------------------
module rare_allele_pair_sharing import raps_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 256,
  parameter int unsigned NUM_BINS    = 4,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_regs_t regs;

  assign cfg_pready = 1'b1;

  raps_cfg #(.AW(5)) u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .regs
  );

  raps_core #(.MAX_SAMPLES(MAX_SAMPLES), .NUM_BINS(NUM_BINS),
              .COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk, .rst_n, .regs, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

>>> rtl/raps_checker.sv
// ----------------------------------------------------------------------------
// raps_checker
// Port-level checks for the sharing counter.
// ----------------------------------------------------------------------------
module raps_checker import raps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat dropped");

  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind |->
      out_data.site_carriers == '0 && out_data.matched_bin == '0)
    else $error("read beat carries site fields");

  a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.result_kind |-> out_data.matched_bin <= NO_BIN)
    else $error("bad bin");

endmodule

bind rare_allele_pair_sharing raps_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

>>> dv/tb_rare_allele_pair_sharing.sv
// ----------------------------------------------------------------------------
// tb_rare_allele_pair_sharing
// Self-checking bench for the pairwise rare-allele sharing counter. A table
// of directed beats runs first, then random or full-width-site phases under
// changing register settings. Result beats are checked against table values
// or a predictor of carrier calls, bin matches, saturating pair/site counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rare_allele_pair_sharing;
  import raps_pkg::*;

  localparam int unsigned NSAMP_MAX = 256;
  localparam int unsigned NBIN_MAX  = 4;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rare_allele_pair_sharing uut (.*);

  // register shadow
  int unsigned thr_q, nsamp_q, nbins_q;
  int unsigned bin_val[BIN_REGS];

  // predicted block state
  int unsigned site_pos, site_tally;
  int unsigned carrier_idx[NSAMP_MAX];
  int unsigned pair_cnt[int];
  int unsigned site_cnt[NBIN_MAX];

  out_beat_t   want_q[$];
  int          err_cnt;
  bit          quiet;
  bit          hold_req;
  int unsigned carrier_pct;

  typedef struct {
    in_beat_t  b;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  dir_row_t dir_tab[19];
  int unsigned phase_cfg[8][7] = '{
    '{0,      4,   4, 0,   1,   2,   3},
    '{131072, 5,   1, 1,   9,   9,   9},
    '{20000,  8,   7, 3,   2,   257, 511},
    '{65536,  0,   0, 0,   0,   0,   0},
    '{0,      511, 1, 256, 0,   0,   0},
    '{40000,  6,   3, 2,   1,   3,   4},
    '{98304,  7,   2, 1,   2,   0,   0},
    '{32768,  5,   4, 1,   2,   3,   0}
  };

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int eff_n();
    if (nsamp_q < 1) return 1;
    if (nsamp_q > NSAMP_MAX) return NSAMP_MAX;
    return nsamp_q;
  endfunction

  function automatic int eff_bins();
    return (nbins_q > NBIN_MAX) ? NBIN_MAX : nbins_q;
  endfunction

  function automatic int cell_key(int unsigned bn, int unsigned r, int unsigned c);
    return (bn << 16) | (r << 8) | c;
  endfunction

  function automatic void bump_pair(int k);
    if (!pair_cnt.exists(k)) pair_cnt[k] = 0;
    if (pair_cnt[k] != 32'hFFFF_FFFF) pair_cnt[k]++;
  endfunction

  function automatic bit count_beat(in_beat_t b, output out_beat_t r);
    longint unsigned sum, num;
    bit              carrier;
    int              match;
    int unsigned     bn, ri, rj;
    r = '0;
    case (action_t'(b.action)) inside
      ACT_SAMPLE: begin
        sum = longint'(b.lik_hom_ref) + b.lik_het + b.lik_hom_alt;
        num = longint'(b.lik_het) + 2 * longint'(b.lik_hom_alt);
        if (sum == 0) carrier = (thr_q == 0);
        else carrier = (num << 16) >= longint'(thr_q) * sum;
        if (carrier && site_tally < NSAMP_MAX) begin
          carrier_idx[site_tally] = site_pos;
          site_tally++;
        end
        if (site_pos + 1 < eff_n()) begin
          site_pos++;
          return 1'b0;
        end
        match = NO_BIN;
        for (int k = eff_bins() - 1; k >= 0; k--)
          if (bin_val[k] == site_tally) match = k;
        if (match != NO_BIN) begin
          if (site_cnt[match] != 32'hFFFF_FFFF) site_cnt[match]++;
          for (int i = 0; i < site_tally; i++) begin
            ri = carrier_idx[i];
            bump_pair(cell_key(match, ri, ri));
            for (int j = i + 1; j < site_tally; j++) begin
              rj = carrier_idx[j];
              bump_pair(cell_key(match, ri, rj));
              bump_pair(cell_key(match, rj, ri));
            end
          end
        end
        r.result_kind   = 1'b0;
        r.site_carriers = site_tally[8:0];
        r.matched_bin   = match[2:0];
        site_pos   = 0;
        site_tally = 0;
        return 1'b1;
      end
      ACT_RD_PAIR, ACT_RD_BIN: begin
        bn = 32'(b.bin_select);
        r.result_kind = 1'b1;
        if (bn < eff_bins()) begin
          if (action_t'(b.action) == ACT_RD_BIN) r.read_value = site_cnt[bn];
          else if (b.row_sample < eff_n() && b.col_sample < eff_n() &&
                   pair_cnt.exists(cell_key(bn, b.row_sample, b.col_sample)))
            r.read_value = pair_cnt[cell_key(bn, b.row_sample, b.col_sample)];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_beat(in_beat_t b, bit typed = 1'b0, out_beat_t want = '0);
    out_beat_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (count_beat(b, r)) want_q.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (idx) inside
      REG_THR:   thr_q   = val & 32'h3FFFF;
      REG_NSAMP: nsamp_q = val & 32'h1FF;
      REG_NBINS: nbins_q = val & 32'h7;
      REG_BIN_A, REG_BIN_B, REG_BIN_C, REG_BIN_D:
        bin_val[idx - REG_BIN_A] = val & 32'h1FF;
      default: ;
    endcase
  endtask

  function automatic in_beat_t lik_beat(int unsigned r, int unsigned h, int unsigned a);
    in_beat_t b;
    b = '0;
    b.action      = ACT_SAMPLE;
    b.lik_hom_ref = 16'(r);
    b.lik_het     = 16'(h);
    b.lik_hom_alt = 16'(a);
    return b;
  endfunction

  function automatic in_beat_t read_beat(action_t act, int unsigned bn, int unsigned r,
                                         int unsigned c);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom});
    b.action     = act;
    b.bin_select = 2'(bn);
    b.row_sample = 8'(r);
    b.col_sample = 8'(c);
    return b;
  endfunction

  function automatic in_beat_t rand_beat();
    int unsigned sel;
    in_beat_t    b;
    sel = $urandom_range(0, 99);
    if (site_pos == 0) carrier_pct = $urandom_range(0, 60);
    if (sel < 65) begin
      b = lik_beat($urandom, $urandom, $urandom);
      sel = $urandom_range(0, 99);
      if (sel < 8) b = lik_beat(0, 0, 0);
      else if (sel < 8 + carrier_pct) b = lik_beat(0, $urandom_range(0, 4000), $urandom);
      else if (sel < 80) b = lik_beat($urandom | 16'h8000, $urandom_range(0, 200), 0);
    end else if (sel < 95) begin
      b = read_beat(sel < 80 ? ACT_RD_BIN : ACT_RD_PAIR, $urandom_range(0, 3),
                    $urandom_range(0, eff_n() - 1), $urandom_range(0, eff_n() - 1));
      if ($urandom_range(0, 7) == 0) begin
        b.row_sample = 8'($urandom);
        b.col_sample = 8'($urandom);
      end
    end else begin
      b = in_beat_t'({$urandom, $urandom, $urandom});
      b.action = ACT_NONE;
    end
    return b;
  endfunction

  // receiver side
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data);
        err_cnt++;
      end else begin
        out_beat_t w;
        w = want_q.pop_front();
        if (out_data.result_kind !== w.result_kind) begin
          $display("%0t: result_kind exp %0d got %0d", $time, w.result_kind,
                   out_data.result_kind);
          err_cnt++;
        end
        if (out_data.site_carriers !== w.site_carriers) begin
          $display("%0t: site_carriers exp %0d got %0d", $time, w.site_carriers,
                   out_data.site_carriers);
          err_cnt++;
        end
        if (out_data.matched_bin !== w.matched_bin) begin
          $display("%0t: matched_bin exp %0d got %0d", $time, w.matched_bin,
                   out_data.matched_bin);
          err_cnt++;
        end
        if (out_data.read_value !== w.read_value) begin
          $display("%0t: read_value exp %0d got %0d", $time, w.read_value,
                   out_data.read_value);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("tb_rare_allele_pair_sharing: errors");
    $finish;
  end

  initial begin
    out_beat_t rd0, site2;
    err_cnt = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    carrier_pct = 20;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    thr_q = 32768;
    nsamp_q = 256;
    nbins_q = 4;
    bin_val = '{2, 3, 4, 5};
    site_pos = 0;
    site_tally = 0;
    site_cnt = '{0, 0, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rd0   = '{result_kind: 1'b1, default: '0};
    site2 = '{result_kind: 1'b0, site_carriers: 9'd2, matched_bin: 3'd0, read_value: '0};
    dir_tab[0]  = '{read_beat(ACT_RD_BIN, 0, 0, 0), 1, rd0};
    dir_tab[1]  = '{read_beat(ACT_RD_PAIR, 0, 0, 0), 1, rd0};
    dir_tab[2]  = '{read_beat(ACT_NONE, 3, 255, 255), 0, '0};
    dir_tab[3]  = '{lik_beat(16'hFFFF, 16'hFFFF, 16'hFFFF), 0, '0};
    dir_tab[4]  = '{read_beat(ACT_RD_BIN, 0, 0, 0), 1, rd0};
    dir_tab[5]  = '{lik_beat(0, 0, 0), 0, '0};
    dir_tab[6]  = '{lik_beat(0, 0, 16'hFFFF), 1, site2};
    dir_tab[7]  = '{read_beat(ACT_RD_BIN, 0, 0, 0), 0, '0};
    dir_tab[8]  = '{read_beat(ACT_RD_PAIR, 0, 0, 2), 0, '0};
    dir_tab[9]  = '{read_beat(ACT_RD_PAIR, 0, 2, 0), 0, '0};
    dir_tab[10] = '{read_beat(ACT_RD_PAIR, 0, 1, 1), 0, '0};
    dir_tab[11] = '{read_beat(ACT_RD_PAIR, 0, 255, 0), 1, rd0};
    dir_tab[12] = '{lik_beat(16'hFFFF, 0, 0), 0, '0};
    dir_tab[13] = '{lik_beat(0, 16'hFFFF, 0), 0, '0};
    dir_tab[14] = '{lik_beat(0, 0, 1), 0, '0};
    dir_tab[15] = '{lik_beat(1, 1, 16'hFFFF), 0, '0};
    dir_tab[16] = '{lik_beat(0, 16'hFFFF, 16'hFFFF), 0, '0};
    dir_tab[17] = '{lik_beat(16'hFFFF, 16'hFFFF, 0), 0, '0};
    dir_tab[18] = '{read_beat(ACT_RD_BIN, 1, 0, 0), 0, '0};

    write_reg(REG_NSAMP, 3);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    foreach (dir_tab[i]) send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    foreach (phase_cfg[p]) begin
      for (int r = 0; r < 7; r++) write_reg(reg_idx_t'(r), phase_cfg[p][r]);
      quiet = (p == 7);
      if (eff_n() == NSAMP_MAX) begin
        // one full-width site, every sample a carrier
        for (int i = 0; i < NSAMP_MAX; i++)
          send_beat(lik_beat($urandom, $urandom, $urandom));
        for (int i = 0; i < 60; i++)
          send_beat(read_beat(ACT_RD_PAIR, 0, $urandom, $urandom));
        send_beat(read_beat(ACT_RD_BIN, 0, 0, 0));
      end else begin
        for (int i = 0; i < 250; i++) begin
          if (p == 5 && i == 100) hold_req = 1'b1;
          if (p == 2 && i == 125) wait_drained();
          send_beat(rand_beat());
        end
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("tb_rare_allele_pair_sharing: clean");
    end else begin
      $display("tb_rare_allele_pair_sharing: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/raps_pkg.sv
rtl/raps_cfg.sv
rtl/raps_carrier.sv
rtl/raps_core.sv
rtl/rare_allele_pair_sharing.sv
rtl/raps_checker.sv
dv/tb_rare_allele_pair_sharing.sv
